// ----- rtl/bdac_pkg.sv -----
// Shared types and constants for the binary to decimal ASCII converter.
// Depends on nothing; every other file in rtl/ imports it.
`timescale 1ns / 1ps
package bdac_pkg;

	// Internal BCD register is wide enough for any 64-bit value
	localparam int DD_DIGITS = 20;
	localparam int DD_W      = DD_DIGITS * 4;
	localparam int CNT_W     = 5;
	localparam int CHAR_W    = 6;
	localparam logic [CHAR_W-1:0] CHAR_ZERO = 6'd48;

	// Two-entry queue between front and back
	localparam int Q_DEPTH = 2;
	localparam int QPTR_W  = $clog2(Q_DEPTH);
	localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

	typedef struct packed {
		logic [63:0]      value;
		logic [CNT_W-1:0] digit_count;
	} in_beat_t;

	typedef struct packed {
		logic [CHAR_W-1:0] digit_char;
		logic              last;
		logic              width_raised;
	} out_beat_t;

	// One converted item waiting for emission
	typedef struct packed {
		logic [DD_W-1:0]  digits;
		logic [CNT_W-1:0] count;
		logic             raised;
	} q_entry_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_CONV,
		F_PUSH
	} front_state_t;

	typedef enum logic {
		B_IDLE,
		B_EMIT
	} back_state_t;

endpackage

// ----- rtl/binary_to_decimal_ascii_core.sv -----
// Path: the front converts in F_CONV and pushes in F_PUSH; the back pops in B_IDLE and registers digits in B_EMIT.
// Flow: the front converter shifts in 4 bits per cycle of shift-and-add-3 and takes no new item until
// it has pushed the last one, which waits while the queue is full; the back emits count digits per
// item, and out_ready can stall it.
// Reset: arst_n clears the control state of both ends and the queue; no clearing pass.
// Top level of the converter; instantiates bdac_front, bdac_queue and bdac_back.
`timescale 1ns / 1ps
module binary_to_decimal_ascii_core #(
	parameter int VALUE_BITS = 64,
	parameter int MAX_DIGITS = 20
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  bdac_pkg::in_beat_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output bdac_pkg::out_beat_t out_data
);
	import bdac_pkg::*;

	logic     push, pop, q_full, q_empty;
	q_entry_t push_entry, pop_entry;

	bdac_front #(
		.VALUE_BITS(VALUE_BITS),
		.MAX_DIGITS(MAX_DIGITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.push      (push),
		.push_entry(push_entry),
		.q_full    (q_full)
	);

	bdac_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_entry(push_entry),
		.full      (q_full),
		.pop       (pop),
		.pop_entry (pop_entry),
		.empty     (q_empty)
	);

	bdac_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.pop_entry(pop_entry),
		.pop      (pop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

endmodule

// ----- rtl/bdac_front.sv -----
// Front end: accepts a beat, converts to BCD by shift-and-add-3, 4 bits per cycle,
// then works out the digit count and pushes one entry into the queue. Uses bdac_pkg.
`timescale 1ns / 1ps
module bdac_front #(
	parameter int VALUE_BITS = 64,
	parameter int MAX_DIGITS = 20
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  bdac_pkg::in_beat_t in_data,
	output logic              push,
	output bdac_pkg::q_entry_t push_entry,
	input  logic              q_full
);
	import bdac_pkg::*;

	localparam int STEPS  = (VALUE_BITS + 3) / 4;
	localparam int SH_W   = STEPS * 4;
	localparam int STEP_W = (STEPS > 1) ? $clog2(STEPS) : 1;

	front_state_t state_q, state_n;
	logic [STEP_W-1:0] step_q;
	logic [SH_W-1:0]   sh_q, sh_n;
	logic [DD_W-1:0]   bcd_q, bcd_n;
	logic [CNT_W-1:0]  req_q;
	logic [CNT_W-1:0]  needed, cnt;
	logic              raised;
	logic              accept;

	assign accept = in_valid && in_ready;

	// Next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			F_IDLE: begin
				if (in_valid) state_n = F_CONV;
			end
			F_CONV: begin
				if (step_q == STEP_W'(STEPS - 1)) state_n = F_PUSH;
			end
			F_PUSH: begin
				if (!q_full) state_n = F_IDLE;
			end
			default: state_n = F_IDLE;
		endcase
	end

	// FSM outputs
	always_comb begin
		in_ready = 1'b0;
		push     = 1'b0;
		unique case (state_q)
			F_IDLE:  in_ready = 1'b1;
			F_CONV:  ;
			F_PUSH:  push = !q_full;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_n;
			if (accept) step_q <= '0;
			else if (state_q == F_CONV) step_q <= step_q + STEP_W'(1);
		end
	end

	// Four shift-and-add-3 steps per cycle, msb of the value first
	always_comb begin
		bcd_n = bcd_q;
		sh_n  = sh_q;
		for (int b = 0; b < 4; b++) begin
			for (int d = 0; d < DD_DIGITS; d++) begin
				if (bcd_n[d*4 +: 4] >= 4'd5) bcd_n[d*4 +: 4] = bcd_n[d*4 +: 4] + 4'd3;
			end
			bcd_n = {bcd_n[DD_W-2:0], sh_n[SH_W-1]};
			sh_n  = {sh_n[SH_W-2:0], 1'b0};
		end
	end

	// Conversion datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			sh_q  <= SH_W'(in_data.value[VALUE_BITS-1:0]);
			bcd_q <= '0;
			req_q <= in_data.digit_count;
		end else if (state_q == F_CONV) begin
			sh_q  <= sh_n;
			bcd_q <= bcd_n;
		end
	end

	// Digits needed: position of highest nonzero digit, at least one
	always_comb begin
		needed = CNT_W'(1);
		for (int d = 0; d < DD_DIGITS; d++) begin
			if (bcd_q[d*4 +: 4] != 4'd0) needed = CNT_W'(d + 1);
		end
	end

	// Raise a short request, then saturate at the output width
	always_comb begin
		cnt    = req_q;
		raised = 1'b0;
		if (req_q < needed) begin
			cnt    = needed;
			raised = 1'b1;
		end
		if (cnt > CNT_W'(MAX_DIGITS)) cnt = CNT_W'(MAX_DIGITS);
	end

	assign push_entry.digits = bcd_q;
	assign push_entry.count  = cnt;
	assign push_entry.raised = raised;

endmodule

// ----- rtl/bdac_queue.sv -----
// Small register queue of converted items between front and back.
// Uses bdac_pkg for the entry type and depth.
`timescale 1ns / 1ps
module bdac_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  bdac_pkg::q_entry_t push_entry,
	output logic               full,
	input  logic               pop,
	output bdac_pkg::q_entry_t pop_entry,
	output logic               empty
);
	import bdac_pkg::*;

	q_entry_t           mem_q [Q_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0]  fill_q;

	assign full      = (fill_q == QCNT_W'(Q_DEPTH));
	assign empty     = (fill_q == '0);
	assign pop_entry = mem_q[rd_ptr_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) wr_ptr_q <= (wr_ptr_q == QPTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			if (pop)  rd_ptr_q <= (rd_ptr_q == QPTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			if (push && !pop)      fill_q <= fill_q + QCNT_W'(1);
			else if (pop && !push) fill_q <= fill_q - QCNT_W'(1);
		end
	end

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_entry;
	end

endmodule

// ----- rtl/bdac_back.sv -----
// Back end: pops one converted item and emits its digits most significant first
// through an output register. Uses bdac_pkg.
`timescale 1ns / 1ps
module bdac_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_empty,
	input  bdac_pkg::q_entry_t  pop_entry,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_ready,
	output bdac_pkg::out_beat_t out_data
);
	import bdac_pkg::*;

	back_state_t      state_q, state_n;
	q_entry_t         ent_q;
	logic [CNT_W-1:0] idx_q;
	logic             advance;
	logic             out_valid_q;
	out_beat_t        out_q;
	logic [3:0]       digit;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign digit     = ent_q.digits[{idx_q, 2'b00} +: 4];

	// Next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			B_IDLE: begin
				if (!q_empty) state_n = B_EMIT;
			end
			B_EMIT: begin
				if (advance && idx_q == '0) state_n = B_IDLE;
			end
			default: state_n = B_IDLE;
		endcase
	end

	// FSM outputs
	always_comb begin
		pop     = 1'b0;
		advance = 1'b0;
		unique case (state_q)
			B_IDLE:  pop = !q_empty;
			B_EMIT:  advance = !out_valid_q || out_ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (advance)        out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// Item and output payload registers
	always_ff @(posedge clk) begin
		if (pop) begin
			ent_q <= pop_entry;
			idx_q <= pop_entry.count - CNT_W'(1);
		end else if (advance) begin
			idx_q <= idx_q - CNT_W'(1);
		end
		if (advance) begin
			out_q.digit_char   <= CHAR_ZERO + CHAR_W'(digit);
			out_q.last         <= (idx_q == '0);
			out_q.width_raised <= ent_q.raised;
		end
	end

endmodule

// ----- rtl/bdac_checker.sv -----
// Port-level checks for binary_to_decimal_ascii_core, bound to the top level.
// Uses bdac_pkg for the beat types.
`timescale 1ns / 1ps
module bdac_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input bdac_pkg::out_beat_t out_data
);
	import bdac_pkg::*;

	// Stalled output beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output beat changed while stalled");

	// Every character is a decimal digit
	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.digit_char >= CHAR_ZERO) &&
			(out_data.digit_char <= CHAR_ZERO + 6'd9))
		else $error("digit character out of range");

	// Front is busy converting right after taking a beat
	a_front_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("front took a beat while converting");

	// Raised flag stays constant across the digits of one item
	a_raised_steady: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_data.last ##1 out_valid |->
			out_data.width_raised == $past(out_data.width_raised))
		else $error("width_raised changed inside an item");

endmodule

bind binary_to_decimal_ascii_core bdac_checker u_bdac_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_ready (in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.out_data (out_data)
);

// ----- bench/tb_binary_to_decimal_ascii_core.sv -----
// Self-checking bench for binary_to_decimal_ascii_core: a directed table, then random values.
// Every output beat is checked against typed text or a digit-string predictor. Depends on rtl/bdac_pkg.sv
// and the RTL of the core.
`timescale 1ns / 1ps
module tb_binary_to_decimal_ascii_core;
	import bdac_pkg::*;

	localparam int RANDOM_ITEMS = 460;
	localparam int MAX_DIG      = 20;
	localparam int DRAIN_CYCLES = 40;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      in_valid  = 1'b0;
	logic      in_ready;
	in_beat_t  in_data   = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_beat_t out_data;

	binary_to_decimal_ascii_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	// Directed row: expected text typed in where it is obvious, else predicted
	typedef struct {
		logic [63:0]      value;
		logic [CNT_W-1:0] count;
		bit               typed;
		string            text;
		bit               raised;
	} directed_row_t;

	directed_row_t directed_rows[23] = '{
		'{64'd0, 5'd0, 1'b1, "0", 1'b1},
		'{64'd0, 5'd1, 1'b1, "0", 1'b0},
		'{64'd0, 5'd20, 1'b1, "00000000000000000000", 1'b0},
		'{64'hFFFF_FFFF_FFFF_FFFF, 5'd20, 1'b1, "18446744073709551615", 1'b0},
		'{64'hFFFF_FFFF_FFFF_FFFF, 5'd0, 1'b1, "18446744073709551615", 1'b1},
		'{64'hFFFF_FFFF_FFFF_FFFF, 5'd19, 1'b1, "18446744073709551615", 1'b1},
		'{64'hFFFF_FFFF_FFFF_FFFF, 5'd31, 1'b1, "18446744073709551615", 1'b0},
		'{64'd42, 5'd31, 1'b1, "00000000000000000042", 1'b0},
		'{64'd9, 5'd1, 1'b1, "9", 1'b0},
		'{64'd10, 5'd1, 1'b1, "10", 1'b1},
		'{64'd9999999999, 5'd10, 1'b1, "9999999999", 1'b0},
		'{64'd10000000000, 5'd10, 1'b1, "10000000000", 1'b1},
		'{64'd1000000000, 5'd0, 1'b0, "", 1'b0},
		'{64'h0000_0000_FFFF_FFFF, 5'd10, 1'b1, "4294967295", 1'b0},
		'{64'h0000_0001_0000_0000, 5'd0, 1'b0, "", 1'b0},
		'{64'd12345, 5'd21, 1'b0, "", 1'b0},
		'{64'd7, 5'd5, 1'b1, "00007", 1'b0},
		'{64'd10000000000000000000, 5'd20, 1'b1, "10000000000000000000", 1'b0},
		'{64'd9999999999999999999, 5'd19, 1'b1, "9999999999999999999", 1'b0},
		'{64'h8000_0000_0000_0000, 5'd16, 1'b0, "", 1'b0},
		'{64'h5555_5555_5555_5555, 5'd31, 1'b0, "", 1'b0},
		'{64'hAAAA_AAAA_AAAA_AAAA, 5'd10, 1'b0, "", 1'b0},
		'{64'd65535, 5'd5, 1'b0, "", 1'b0}
	};

	// Expected output characters, oldest first
	out_beat_t pending_chars[$];
	out_beat_t want_char;
	int        mismatch_count = 0;

	// Expectation source of the beat currently on the input
	bit    row_typed  = 1'b0;
	string row_text   = "";
	bit    row_raised = 1'b0;

	int burst_left = 1;

	// Receiver stall pattern
	logic [15:0] stall_pattern = 16'hFFFF;
	int          stall_len     = 1;
	int          stall_phase   = 0;
	int          stall_cycle   = 0;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	task automatic report_mismatch(input string msg);
		$display("mismatch @%0t: %s", $time, msg);
		mismatch_count++;
	endtask

	function automatic int digits_needed(input logic [63:0] v);
		int n;
		n = 0;
		while (v != 64'd0) begin
			n++;
			v = v / 64'd10;
		end
		if (n == 0) n = 1;
		return n;
	endfunction

	// Decimal digits of one input beat, padded to the (fixed up) count
	function automatic void predict_chars(input in_beat_t b);
		logic [63:0] v;
		logic [3:0]  digs[MAX_DIG];
		int          needed;
		int          cnt;
		bit          raised;
		out_beat_t   c;
		v = b.value;
		for (int k = 0; k < MAX_DIG; k++) begin
			digs[k] = 4'(v % 64'd10);
			v = v / 64'd10;
		end
		needed = digits_needed(b.value);
		cnt = int'(b.digit_count);
		raised = 1'b0;
		if (cnt < needed) begin
			cnt = needed;
			raised = 1'b1;
		end
		if (cnt > MAX_DIG) cnt = MAX_DIG;
		for (int k = 0; k < cnt; k++) begin
			c.digit_char   = CHAR_ZERO + CHAR_W'(digs[cnt - 1 - k]);
			c.last         = (k + 1 == cnt);
			c.width_raised = raised;
			pending_chars.push_back(c);
		end
	endfunction

	function automatic void push_typed(input string text, input bit raised);
		out_beat_t c;
		for (int i = 0; i < text.len(); i++) begin
			c.digit_char   = CHAR_W'(text[i]);
			c.last         = (i == text.len() - 1);
			c.width_raised = raised;
			pending_chars.push_back(c);
		end
	endfunction

	// Random values lean on digit-count boundaries: powers of ten and their neighbors
	function automatic logic [63:0] pick_value();
		logic [63:0] p;
		int          k;
		int          nbits;
		p = 64'd1;
		k = $urandom_range(0, 19);
		for (int i = 0; i < k; i++) p = p * 64'd10;
		case ($urandom_range(0, 5))
			0: return {$urandom, $urandom};
			1: begin
				nbits = $urandom_range(1, 64);
				return {$urandom, $urandom} & (64'hFFFF_FFFF_FFFF_FFFF >> (64 - nbits));
			end
			2: return p;
			3: return (k == 0) ? 64'd0 : p - 64'd1;
			4: return p + 64'($urandom_range(0, 99));
			default: return 64'($urandom_range(0, 999));
		endcase
	endfunction

	function automatic logic [CNT_W-1:0] pick_count(input logic [63:0] v);
		int n;
		n = digits_needed(v);
		case ($urandom_range(0, 4))
			0, 1: return CNT_W'(n + $urandom_range(0, MAX_DIG - n));
			2: return CNT_W'($urandom_range(0, 31));
			3: return (n > 1) ? CNT_W'($urandom_range(0, n - 1)) : CNT_W'(0);
			default: return CNT_W'($urandom_range(0, MAX_DIG));
		endcase
	endfunction

	// Present one beat at the falling edge and hold it until accepted
	task automatic send_beat(input in_beat_t b, input bit typed, input string text,
			input bit raised);
		@(negedge clk);
		in_data    = b;
		row_typed  = typed;
		row_text   = text;
		row_raised = raised;
		in_valid   = 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// Burst pacing: after a burst, drop valid for a random gap
	task automatic pace_sender();
		burst_left--;
		if (burst_left <= 0) begin
			@(negedge clk);
			in_valid = 1'b0;
			repeat ($urandom_range(0, 40)) @(negedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 50)
				: $urandom_range(1, 6);
		end
	endtask

	// Receiver: cycle through a random ready pattern, reloaded now and then
	always @(negedge clk) begin
		if (stall_cycle == 0) begin
			stall_cycle   = $urandom_range(50, 300);
			stall_len     = $urandom_range(2, 16);
			stall_phase   = 0;
			stall_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h1);
		end
		stall_cycle--;
		out_ready <= stall_pattern[stall_phase];
		stall_phase = (stall_phase + 1) % stall_len;
	end

	// Predict on each input beat, check each output beat
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) begin
			if (row_typed) push_typed(row_text, row_raised);
			else predict_chars(in_data);
		end
		if (arst_n && out_valid && out_ready) begin
			if (pending_chars.size() == 0) begin
				report_mismatch($sformatf("unexpected beat char=%0d", out_data.digit_char));
			end else begin
				want_char = pending_chars.pop_front();
				if (out_data.digit_char !== want_char.digit_char)
					report_mismatch($sformatf("digit_char got %0d want %0d",
						out_data.digit_char, want_char.digit_char));
				if (out_data.last !== want_char.last)
					report_mismatch($sformatf("last got %0b want %0b",
						out_data.last, want_char.last));
				if (out_data.width_raised !== want_char.width_raised)
					report_mismatch($sformatf("width_raised got %0b want %0b",
						out_data.width_raised, want_char.width_raised));
			end
		end
	end

	// Stimulus and end of run
	initial begin
		in_beat_t b;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed_rows[i]) begin
			b.value       = directed_rows[i].value;
			b.digit_count = directed_rows[i].count;
			send_beat(b, directed_rows[i].typed, directed_rows[i].text,
				directed_rows[i].raised);
			pace_sender();
		end

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			b.value       = pick_value();
			b.digit_count = pick_count(b.value);
			send_beat(b, 1'b0, "", 1'b0);
			pace_sender();
		end
		@(negedge clk);
		in_valid = 1'b0;

		while (pending_chars.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		if (pending_chars.size() != 0) report_mismatch("expected beats left over");
		$finish;
	end

	// Watchdog
	initial begin
		#10_000_000;
		$display("status: fail");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/bdac_pkg.sv
rtl/bdac_front.sv
rtl/bdac_queue.sv
rtl/bdac_back.sv
rtl/binary_to_decimal_ascii_core.sv
rtl/bdac_checker.sv
bench/tb_binary_to_decimal_ascii_core.sv
